### src/gpde_pkg.sv
`default_nettype none
package gpde_pkg;

  localparam int SAMPLES_DEF  = 64;
  localparam int FFT_SIZE_DEF = 128;

  localparam int SAMPLE_W = 16;
  localparam int LAG_W    = 7;
  localparam int LEVEL_W  = 16;
  localparam int COMP_W   = 32;
  localparam int CPLX_W   = 2 * COMP_W;
  localparam int TDATA_W  = 32;
  localparam int ITER_W   = 5;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Datapath operation issued by the sequencer for one cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_BF_RD_E,
    OP_BF_RD_O,
    OP_BF_MUL,
    OP_BF_SUM,
    OP_BF_WR_E,
    OP_BF_WR_O,
    OP_PH_RD,
    OP_PH_MUL,
    OP_PH_SUM,
    OP_PH_NORM,
    OP_PH_SQ,
    OP_PH_ADD,
    OP_PH_SQRT,
    OP_PH_DSET,
    OP_PH_DIV,
    OP_PH_WR,
    OP_CP_RD,
    OP_CP_WR,
    OP_PK_RD,
    OP_PK_CMP,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sel_b;
    logic inverse;
  } dp_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic out_free;
  } dp_stat_t;

  // Q1.15 sine of 2*pi*m/2^log2n from a Taylor series in Q2.30.
  function automatic logic [15:0] sine_q15(int unsigned m, int unsigned log2n);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          q;
    x    = (64'd2 * 64'(m) * PI_Q30) >> log2n;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return q[15:0];
  endfunction

endpackage
`default_nettype wire

### src/gpde_ram.sv
`default_nettype none
module gpde_ram #(
  parameter int WIDTH = gpde_pkg::CPLX_W,
  parameter int DEPTH = gpde_pkg::FFT_SIZE_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/gpde_datapath.sv
`default_nettype none
module gpde_datapath #(
  parameter int SAMPLES  = gpde_pkg::SAMPLES_DEF,
  parameter int FFT_SIZE = gpde_pkg::FFT_SIZE_DEF,
  localparam int L  = $clog2(FFT_SIZE),
  localparam int SW = $clog2(L),
  localparam int IW = $clog2((FFT_SIZE > 2 * SAMPLES) ? FFT_SIZE : 2 * SAMPLES)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire gpde_pkg::dp_cmd_t             cmd,
  input  wire logic [IW-1:0]                 idx,
  input  wire logic [SW-1:0]                 stage,
  input  wire logic [gpde_pkg::ITER_W-1:0]   iter,
  input  wire logic [gpde_pkg::TDATA_W-1:0]  in_data,
  output gpde_pkg::dp_stat_t                 stat,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic [gpde_pkg::TDATA_W-1:0]       res_data
);

  localparam int HALF = FFT_SIZE / 2;
  localparam int QTR  = FFT_SIZE / 4;
  localparam int SL   = QTR + 1;
  localparam int TIW  = $clog2(SL);
  localparam int CW   = $clog2(FFT_SIZE + 1);
  localparam int LIM  = (SAMPLES < FFT_SIZE) ? SAMPLES : FFT_SIZE;
  localparam int OFF  = (SAMPLES - 1) % FFT_SIZE;
  localparam int MW   = (IW > CW) ? IW : CW;
  localparam int NUMW = 46;

  function automatic logic [L-1:0] bitrev(logic [L-1:0] v);
    logic [L-1:0] r;
    for (int b = 0; b < L; b++) begin
      r[L-1-b] = v[b];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -35'sd2147483647) begin
      return 32'h8000_0001;
    end
    return v[31:0];
  endfunction

  // Quarter-wave sine table, fixed at elaboration.
  logic [15:0] sine_tab [SL];
  for (genvar g = 0; g < SL; g++) begin : g_sine
    assign sine_tab[g] = gpde_pkg::sine_q15(g, L);
  end

  // Two complex stores, imaginary part in the upper half.
  logic          a_we, b_we;
  logic [L-1:0]  a_waddr, b_waddr, a_raddr, b_raddr;
  logic [63:0]   a_wdata, b_wdata, a_rdata, b_rdata;

  gpde_ram #(.WIDTH(gpde_pkg::CPLX_W), .DEPTH(FFT_SIZE)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  gpde_ram #(.WIDTH(gpde_pkg::CPLX_W), .DEPTH(FFT_SIZE)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  logic [CW-1:0] count;
  logic          room;
  assign room = (count < CW'(LIM));

  // Butterfly addressing: insert a zero at bit "stage" of the butterfly index.
  logic [L-2:0] bfly, mask, lowp, highp, tw;
  logic [L-1:0] e_addr, o_addr, tt;
  logic [SW:0]  tw_sh;
  assign bfly   = idx[L-2:0];
  assign mask   = ~((~(L-1)'(0)) << stage);
  assign lowp   = bfly & mask;
  assign highp  = bfly & ~mask;
  assign e_addr = {highp, 1'b0} | {1'b0, lowp};
  assign o_addr = e_addr | (L'(1) << stage);
  assign tw_sh  = (SW + 1)'(L - 1) - {1'b0, stage};
  assign tw     = lowp << tw_sh;
  assign tt     = {1'b0, tw};

  logic signed [15:0] tw_c, tw_s;
  always_comb begin
    if (tt <= L'(QTR)) begin
      tw_c = sine_tab[TIW'(L'(QTR) - tt)];
      tw_s = sine_tab[TIW'(tt)];
    end else begin
      tw_c = -sine_tab[TIW'(tt - L'(QTR))];
      tw_s = sine_tab[TIW'(L'(HALF) - tt)];
    end
  end

  logic [63:0]        rd;
  logic signed [31:0] rd_re, rd_im;
  logic signed [31:0] a_re, a_im, b_re, b_im;
  assign rd    = cmd.sel_b ? b_rdata : a_rdata;
  assign rd_re = rd[31:0];
  assign rd_im = rd[63:32];
  assign a_re  = a_rdata[31:0];
  assign a_im  = a_rdata[63:32];
  assign b_re  = b_rdata[31:0];
  assign b_im  = b_rdata[63:32];

  // Butterfly registers.
  logic signed [15:0] wr, wi;
  logic signed [31:0] e_re, e_im;
  logic signed [47:0] m_rr, m_ii, m_ri, m_ir;
  logic signed [33:0] p_re, p_im;
  logic signed [48:0] s_re, s_im;
  assign s_re = 49'(m_rr) - 49'(m_ii) + 49'sd16384;
  assign s_im = 49'(m_ri) + 49'(m_ir) + 49'sd16384;

  // Normalization registers.
  logic signed [63:0] x_rr, x_ii, x_ri, x_ir;
  logic signed [63:0] c_re, c_im;
  logic               neg_re, neg_im;
  logic [62:0]        ar, ai;
  logic [59:0]        sq_r, sq_i;
  logic [60:0]        rem, root, sq_bit, trial;
  logic [5:0]         sq_sh;
  logic [NUMW-1:0]    num_re, num_im, dv;
  logic [30:0]        den;
  logic [15:0]        q_re, q_im;
  logic [3:0]         dsh;
  logic [31:0]        u_re, u_im, o_re, o_im;
  logic               bin_zero;

  assign c_re   = x_rr + x_ii;
  assign c_im   = x_ri - x_ir;
  assign sq_sh  = 6'd60 - {iter, 1'b0};
  assign sq_bit = 61'(1) << sq_sh;
  assign trial  = root + sq_bit;
  assign dsh    = 4'(5'd15 - iter);
  assign dv     = NUMW'(den) << dsh;
  assign u_re   = q_re[15] ? 32'd32767 : 32'(q_re);
  assign u_im   = q_im[15] ? 32'd32767 : 32'(q_im);
  assign o_re   = neg_re ? -u_re : u_re;
  assign o_im   = neg_im ? -u_im : u_im;
  assign bin_zero = (den == '0) || (idx[L-1:0] == '0) || (idx[L-1:0] == L'(HALF));

  // Peak search.
  logic [L-1:0]       pk_addr;
  logic signed [32:0] pk_v;
  logic [31:0]        pk_m, best;
  logic [IW-1:0]      best_i;
  logic [15:0]        lag_full, pos_full;
  assign pk_addr  = idx[L-1:0] - L'(OFF);
  assign pk_v     = (33'(b_re) + 33'(HALF)) >>> L;
  assign pk_m     = pk_v[32] ? 32'(-pk_v) : 32'(pk_v);
  assign lag_full = 16'(best_i) - 16'(SAMPLES - 1);
  assign pos_full = 16'(best_i);

  assign stat = '{norm_done: ((ar[62:30] | ai[62:30]) == '0),
                  out_free:  (!res_valid || res_ready)};

  // Memory port control.
  always_comb begin
    a_we    = 1'b0;
    b_we    = 1'b0;
    a_waddr = '0;
    b_waddr = '0;
    a_wdata = '0;
    b_wdata = '0;
    a_raddr = '0;
    b_raddr = '0;
    case (cmd.op)
      gpde_pkg::OP_LOAD: begin
        a_we    = room;
        b_we    = room;
        a_waddr = bitrev(count[L-1:0]);
        b_waddr = bitrev(count[L-1:0]);
        a_wdata = {32'd0, {16{in_data[15]}}, in_data[15:0]};
        b_wdata = {32'd0, {16{in_data[31]}}, in_data[31:16]};
      end
      gpde_pkg::OP_CLEAR: begin
        a_we    = (MW'(idx) >= MW'(count));
        b_we    = (MW'(idx) >= MW'(count));
        a_waddr = bitrev(idx[L-1:0]);
        b_waddr = bitrev(idx[L-1:0]);
      end
      gpde_pkg::OP_BF_RD_E: begin
        a_raddr = e_addr;
        b_raddr = e_addr;
      end
      gpde_pkg::OP_BF_RD_O: begin
        a_raddr = o_addr;
        b_raddr = o_addr;
      end
      gpde_pkg::OP_BF_WR_E: begin
        a_we    = !cmd.sel_b;
        b_we    = cmd.sel_b;
        a_waddr = e_addr;
        b_waddr = e_addr;
        a_wdata = {sat32(35'(e_im) + 35'(p_im)), sat32(35'(e_re) + 35'(p_re))};
        b_wdata = a_wdata;
      end
      gpde_pkg::OP_BF_WR_O: begin
        a_we    = !cmd.sel_b;
        b_we    = cmd.sel_b;
        a_waddr = o_addr;
        b_waddr = o_addr;
        a_wdata = {sat32(35'(e_im) - 35'(p_im)), sat32(35'(e_re) - 35'(p_re))};
        b_wdata = a_wdata;
      end
      gpde_pkg::OP_PH_RD: begin
        a_raddr = idx[L-1:0];
        b_raddr = idx[L-1:0];
      end
      gpde_pkg::OP_PH_WR: begin
        a_we    = 1'b1;
        a_waddr = idx[L-1:0];
        a_wdata = bin_zero ? 64'd0 : {o_im, o_re};
      end
      gpde_pkg::OP_CP_RD: begin
        a_raddr = idx[L-1:0];
      end
      gpde_pkg::OP_CP_WR: begin
        b_we    = 1'b1;
        b_waddr = bitrev(idx[L-1:0]);
        b_wdata = a_rdata;
      end
      gpde_pkg::OP_PK_RD: begin
        b_raddr = pk_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (cmd.op)
        gpde_pkg::OP_LOAD: begin
          if (room) begin
            count <= count + CW'(1);
          end
        end
        gpde_pkg::OP_OUT: begin
          count     <= '0;
          res_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      gpde_pkg::OP_BF_RD_E: begin
        wr <= tw_c;
        wi <= cmd.inverse ? tw_s : -tw_s;
      end
      gpde_pkg::OP_BF_RD_O: begin
        e_re <= rd_re;
        e_im <= rd_im;
      end
      gpde_pkg::OP_BF_MUL: begin
        m_rr <= 48'(wr) * 48'(rd_re);
        m_ii <= 48'(wi) * 48'(rd_im);
        m_ri <= 48'(wr) * 48'(rd_im);
        m_ir <= 48'(wi) * 48'(rd_re);
      end
      gpde_pkg::OP_BF_SUM: begin
        p_re <= 34'(s_re >>> 15);
        p_im <= 34'(s_im >>> 15);
      end
      gpde_pkg::OP_PH_MUL: begin
        x_rr <= 64'(a_re) * 64'(b_re);
        x_ii <= 64'(a_im) * 64'(b_im);
        x_ri <= 64'(a_re) * 64'(b_im);
        x_ir <= 64'(a_im) * 64'(b_re);
      end
      gpde_pkg::OP_PH_SUM: begin
        neg_re <= c_re[63];
        neg_im <= c_im[63];
        ar     <= c_re[63] ? 63'(-c_re) : 63'(c_re);
        ai     <= c_im[63] ? 63'(-c_im) : 63'(c_im);
      end
      gpde_pkg::OP_PH_NORM: begin
        if (!stat.norm_done) begin
          ar <= ar >> 1;
          ai <= ai >> 1;
        end
      end
      gpde_pkg::OP_PH_SQ: begin
        sq_r <= 60'(ar[29:0]) * 60'(ar[29:0]);
        sq_i <= 60'(ai[29:0]) * 60'(ai[29:0]);
      end
      gpde_pkg::OP_PH_ADD: begin
        rem  <= 61'(sq_r) + 61'(sq_i);
        root <= '0;
      end
      gpde_pkg::OP_PH_SQRT: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + sq_bit;
        end else begin
          root <= root >> 1;
        end
      end
      gpde_pkg::OP_PH_DSET: begin
        den    <= root[30:0];
        num_re <= {1'b0, ar[29:0], 15'd0} + NUMW'(root[30:1]);
        num_im <= {1'b0, ai[29:0], 15'd0} + NUMW'(root[30:1]);
        q_re   <= '0;
        q_im   <= '0;
      end
      gpde_pkg::OP_PH_DIV: begin
        if (num_re >= dv) begin
          num_re <= num_re - dv;
          q_re   <= q_re | (16'd1 << dsh);
        end
        if (num_im >= dv) begin
          num_im <= num_im - dv;
          q_im   <= q_im | (16'd1 << dsh);
        end
      end
      gpde_pkg::OP_PK_CMP: begin
        if ((idx == '0) || (pk_m > best)) begin
          best   <= pk_m;
          best_i <= idx;
        end
      end
      gpde_pkg::OP_OUT: begin
        res_data <= {2'b00,
                     (best[31:16] != '0) ? 16'hFFFF : best[15:0],
                     pos_full[6:0],
                     lag_full[6:0]};
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### src/gpde_ctrl.sv
`default_nettype none
module gpde_ctrl #(
  parameter int SAMPLES  = gpde_pkg::SAMPLES_DEF,
  parameter int FFT_SIZE = gpde_pkg::FFT_SIZE_DEF,
  localparam int L  = $clog2(FFT_SIZE),
  localparam int SW = $clog2(L),
  localparam int IW = $clog2((FFT_SIZE > 2 * SAMPLES) ? FFT_SIZE : 2 * SAMPLES)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_last,
  output logic                             in_ready,
  input  wire gpde_pkg::dp_stat_t          stat,
  output gpde_pkg::dp_cmd_t                cmd,
  output logic [IW-1:0]                    idx,
  output logic [SW-1:0]                    stage,
  output logic [gpde_pkg::ITER_W-1:0]      iter
);

  typedef enum logic [22:0] {
    ST_LOAD    = 23'd1 << 0,
    ST_CLEAR   = 23'd1 << 1,
    ST_BF_E    = 23'd1 << 2,
    ST_BF_O    = 23'd1 << 3,
    ST_BF_MUL  = 23'd1 << 4,
    ST_BF_SUM  = 23'd1 << 5,
    ST_BF_WE   = 23'd1 << 6,
    ST_BF_WO   = 23'd1 << 7,
    ST_PH_RD   = 23'd1 << 8,
    ST_PH_MUL  = 23'd1 << 9,
    ST_PH_SUM  = 23'd1 << 10,
    ST_PH_NORM = 23'd1 << 11,
    ST_PH_SQ   = 23'd1 << 12,
    ST_PH_ADD  = 23'd1 << 13,
    ST_PH_SQRT = 23'd1 << 14,
    ST_PH_DSET = 23'd1 << 15,
    ST_PH_DIV  = 23'd1 << 16,
    ST_PH_WR   = 23'd1 << 17,
    ST_CP_RD   = 23'd1 << 18,
    ST_CP_WR   = 23'd1 << 19,
    ST_PK_RD   = 23'd1 << 20,
    ST_PK_CMP  = 23'd1 << 21,
    ST_OUT     = 23'd1 << 22
  } state_t;

  typedef enum logic [1:0] {
    PASS_A,
    PASS_B,
    PASS_INV
  } pass_t;

  localparam int SQRT_LAST = 30;
  localparam int DIV_LAST  = 15;

  state_t                      state, state_next;
  pass_t                       pass, pass_next;
  logic [IW-1:0]               idx_next;
  logic [SW-1:0]               stage_next;
  logic [gpde_pkg::ITER_W-1:0] iter_next;
  logic                        last_bin;

  assign last_bin = (idx == IW'(FFT_SIZE - 1));
  assign in_ready = (state == ST_LOAD);

  always_comb begin
    state_next  = state;
    pass_next   = pass;
    idx_next    = idx;
    stage_next  = stage;
    iter_next   = iter;
    cmd.op      = gpde_pkg::OP_NONE;
    cmd.sel_b   = (pass != PASS_A);
    cmd.inverse = (pass == PASS_INV);
    case (state)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.op = gpde_pkg::OP_LOAD;
          if (in_last) begin
            state_next = ST_CLEAR;
            idx_next   = '0;
          end
        end
      end
      ST_CLEAR: begin
        cmd.op   = gpde_pkg::OP_CLEAR;
        idx_next = idx + IW'(1);
        if (last_bin) begin
          state_next = ST_BF_E;
          idx_next   = '0;
          stage_next = '0;
          pass_next  = PASS_A;
        end
      end
      ST_BF_E: begin
        cmd.op     = gpde_pkg::OP_BF_RD_E;
        state_next = ST_BF_O;
      end
      ST_BF_O: begin
        cmd.op     = gpde_pkg::OP_BF_RD_O;
        state_next = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        cmd.op     = gpde_pkg::OP_BF_MUL;
        state_next = ST_BF_SUM;
      end
      ST_BF_SUM: begin
        cmd.op     = gpde_pkg::OP_BF_SUM;
        state_next = ST_BF_WE;
      end
      ST_BF_WE: begin
        cmd.op     = gpde_pkg::OP_BF_WR_E;
        state_next = ST_BF_WO;
      end
      ST_BF_WO: begin
        cmd.op     = gpde_pkg::OP_BF_WR_O;
        state_next = ST_BF_E;
        idx_next   = idx + IW'(1);
        if (idx == IW'(FFT_SIZE / 2 - 1)) begin
          idx_next   = '0;
          stage_next = stage + SW'(1);
          if (stage == SW'(L - 1)) begin
            stage_next = '0;
            case (pass)
              PASS_A: begin
                pass_next = PASS_B;
              end
              PASS_B: begin
                state_next = ST_PH_RD;
              end
              default: begin
                state_next = ST_PK_RD;
              end
            endcase
          end
        end
      end
      ST_PH_RD: begin
        cmd.op     = gpde_pkg::OP_PH_RD;
        state_next = ST_PH_MUL;
      end
      ST_PH_MUL: begin
        cmd.op     = gpde_pkg::OP_PH_MUL;
        state_next = ST_PH_SUM;
      end
      ST_PH_SUM: begin
        cmd.op     = gpde_pkg::OP_PH_SUM;
        state_next = ST_PH_NORM;
      end
      ST_PH_NORM: begin
        cmd.op = gpde_pkg::OP_PH_NORM;
        if (stat.norm_done) begin
          state_next = ST_PH_SQ;
        end
      end
      ST_PH_SQ: begin
        cmd.op     = gpde_pkg::OP_PH_SQ;
        state_next = ST_PH_ADD;
      end
      ST_PH_ADD: begin
        cmd.op     = gpde_pkg::OP_PH_ADD;
        state_next = ST_PH_SQRT;
        iter_next  = '0;
      end
      ST_PH_SQRT: begin
        cmd.op    = gpde_pkg::OP_PH_SQRT;
        iter_next = iter + gpde_pkg::ITER_W'(1);
        if (iter == gpde_pkg::ITER_W'(SQRT_LAST)) begin
          state_next = ST_PH_DSET;
        end
      end
      ST_PH_DSET: begin
        cmd.op     = gpde_pkg::OP_PH_DSET;
        state_next = ST_PH_DIV;
        iter_next  = '0;
      end
      ST_PH_DIV: begin
        cmd.op    = gpde_pkg::OP_PH_DIV;
        iter_next = iter + gpde_pkg::ITER_W'(1);
        if (iter == gpde_pkg::ITER_W'(DIV_LAST)) begin
          state_next = ST_PH_WR;
        end
      end
      ST_PH_WR: begin
        cmd.op     = gpde_pkg::OP_PH_WR;
        state_next = ST_PH_RD;
        idx_next   = idx + IW'(1);
        if (last_bin) begin
          state_next = ST_CP_RD;
          idx_next   = '0;
        end
      end
      ST_CP_RD: begin
        cmd.op     = gpde_pkg::OP_CP_RD;
        state_next = ST_CP_WR;
      end
      ST_CP_WR: begin
        cmd.op     = gpde_pkg::OP_CP_WR;
        state_next = ST_CP_RD;
        idx_next   = idx + IW'(1);
        if (last_bin) begin
          state_next = ST_BF_E;
          idx_next   = '0;
          stage_next = '0;
          pass_next  = PASS_INV;
        end
      end
      ST_PK_RD: begin
        cmd.op     = gpde_pkg::OP_PK_RD;
        state_next = ST_PK_CMP;
      end
      ST_PK_CMP: begin
        cmd.op     = gpde_pkg::OP_PK_CMP;
        state_next = ST_PK_RD;
        idx_next   = idx + IW'(1);
        if (idx == IW'(2 * SAMPLES - 2)) begin
          state_next = ST_OUT;
          idx_next   = '0;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.op     = gpde_pkg::OP_OUT;
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      pass  <= PASS_A;
      idx   <= '0;
      stage <= '0;
      iter  <= '0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      idx   <= idx_next;
      stage <= stage_next;
      iter  <= iter_next;
    end
  end

endmodule
`default_nettype wire

### src/gcc_phat_delay_estimator.sv
// Loading takes one sample pair per cycle. After the last pair of a frame the block is busy with
// the single shared butterfly, which runs all three transforms, with the per-bin normalizer, whose
// bit-serial square root, bit-serial divider and shift search run for each bin, and with the peak search.
// The result enters the output register once the search has ended and the output register is free.
// Reset (synchronous, active high) clears the sequencer, the pair count and the output valid.
`default_nettype none
module gcc_phat_delay_estimator #(
  parameter int SAMPLES  = gpde_pkg::SAMPLES_DEF,
  parameter int FFT_SIZE = gpde_pkg::FFT_SIZE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] sample_a, [31:16] sample_b
  input  wire logic [gpde_pkg::TDATA_W-1:0] s_axis_tdata,
  input  wire logic                         s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [6:0] lag_samples, [13:7] lag_position, [29:14] peak_level, [31:30] zero
  output logic [gpde_pkg::TDATA_W-1:0]      m_axis_tdata
);

  localparam int L  = $clog2(FFT_SIZE);
  localparam int SW = $clog2(L);
  localparam int IW = $clog2((FFT_SIZE > 2 * SAMPLES) ? FFT_SIZE : 2 * SAMPLES);

  // Sequencer to datapath: one operation per cycle plus the loop counters that address it.
  gpde_pkg::dp_cmd_t           cmd;
  gpde_pkg::dp_stat_t          stat;
  logic [IW-1:0]               idx;
  logic [SW-1:0]               stage;
  logic [gpde_pkg::ITER_W-1:0] iter;

  // Each request is taken only while the sequencer sits in its load state. Pairs are written
  // in bit-reversed order so that the forward transforms can run in place without a shuffle.
  gpde_ctrl #(.SAMPLES(SAMPLES), .FFT_SIZE(FFT_SIZE)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd),
    .idx      (idx),
    .stage    (stage),
    .iter     (iter)
  );

  // The datapath holds both sample stores, the butterfly, the normalizer, the peak search and
  // the output register, which lets a new frame load while the last result still waits.
  gpde_datapath #(.SAMPLES(SAMPLES), .FFT_SIZE(FFT_SIZE)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .idx       (idx),
    .stage     (stage),
    .iter      (iter),
    .in_data   (s_axis_tdata),
    .stat      (stat),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire

### src/gpde_checker.sv
`default_nettype none
module gpde_props #(
  parameter int SAMPLES = gpde_pkg::SAMPLES_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic [gpde_pkg::TDATA_W-1:0] s_axis_tdata,
  input wire logic                         s_axis_tlast,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [gpde_pkg::TDATA_W-1:0] m_axis_tdata
);

  // No result is pending right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The last pair of a frame starts the computation, so the input side stops.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken right after the last pair");

  // The signed lag is the window position less the window center.
  a_lag_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[6:0] == 7'(m_axis_tdata[13:7] - 7'(SAMPLES - 1))))
    else $error("lag and position disagree");

  // A new result only comes out of a busy period.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while loading");

endmodule

bind gcc_phat_delay_estimator gpde_props #(.SAMPLES(SAMPLES)) u_gpde_props (.*);
`default_nettype wire
